// ===== hdl/tcie_pkg.sv =====
// Package: shared types and constants of the instruction execute core.
`timescale 1ns / 1ps
`default_nettype none
package tcie_pkg;
   localparam int MemBytes = 32768;
   localparam int AddrW = $clog2(MemBytes);
   localparam int NumRegs = 8;

   typedef enum logic [3:0] {
      OP_HALT = 4'd0, OP_MOVE = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
      OP_MUL = 4'd4, OP_DIV = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7,
      OP_NOT = 4'd8, OP_CMP = 4'd9, OP_JUMP = 4'd10, OP_IN = 4'd11,
      OP_OUT = 4'd12
   } op_type;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_REG = 2'd1;
   localparam logic [1:0] FAULT_DIV = 2'd2;
   localparam logic [1:0] FAULT_SAT = 2'd3;

   localparam logic [3:0] COND_ALWAYS = 4'd0;
   localparam logic [3:0] COND_EQ = 4'd1;
   localparam logic [3:0] COND_GT = 4'd2;
   localparam logic [3:0] COND_LT = 4'd3;

   // Divider handshake.
   typedef struct packed {
      logic        start;
      logic [14:0] dividend;
      logic [14:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [14:0] quotient;
   } div_rsp_type;

   // Byte memory port.
   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] addr;
      logic [7:0]       wdata;
   } mem_req_type;

   function automatic logic signed [16:0] clamp17(input logic signed [17:0] x);
      if (x > 18'sd32767) return 17'sd32767;
      if (x < -18'sd32767) return -17'sd32767;
      return x[16:0];
   endfunction
endpackage
`default_nettype wire

// ===== hdl/toy_cpu_instruction_execute_core.sv =====
// Top level: sequencer, register file and result register of the execute core.
`timescale 1ns / 1ps
`default_nettype none
// Executes one decoded instruction per request over a shared byte memory.
// After reset the core clears its 32768-byte memory and takes no request
// meanwhile. Register and immediate operations go from EXEC to DONE; a
// store adds WR1 (two byte writes on the single memory port), a load adds
// RD0, RD1 and RD2 (two byte reads); divide adds DIV and a wait in DONE for
// the bit-serial divider, so a divide by a word loaded from memory is the
// worst case. One request is in flight at a time; the input reopens the
// cycle after the result is taken.
module toy_cpu_instruction_execute_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_func,
   input  wire logic [3:0]  req_reg_a,
   input  wire logic [3:0]  req_reg_b,
   input  wire logic signed [15:0] req_immediate,
   input  wire logic signed [15:0] req_in_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_next_ip,
   output logic signed [1:0] rsp_cmp_flag,
   output logic [3:0]       rsp_written_index,
   output logic signed [15:0] rsp_written_value,
   output logic             rsp_out_valid,
   output logic signed [15:0] rsp_out_value,
   output logic             rsp_halted,
   output logic [1:0]       rsp_fault
);
   import tcie_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001, ST_EXEC = 8'b00000010, ST_RD0 = 8'b00000100,
      ST_RD1 = 8'b00001000, ST_RD2 = 8'b00010000, ST_WR1 = 8'b00100000,
      ST_DIV = 8'b01000000, ST_DONE = 8'b10000000
   } state_type;

   state_type st_ff, st_in;
   logic signed [15:0] regs [NumRegs];
   logic [3:0]  op_ff, ra_ff, rb_ff;
   logic signed [15:0] imm_ff, inv_ff, av_ff, bv_ff;
   logic [15:0] ip_ff;
   logic signed [1:0] flag_ff;
   logic [7:0]  hi_ff;
   logic [15:0] wword_ff;
   logic        dsign_ff;

   // result register
   logic        rv_ff;
   logic [15:0] nip_ff;
   logic [3:0]  widx_ff;
   logic signed [15:0] wval_ff, oval_ff;
   logic        ov_ff, halt_ff;
   logic [1:0]  fault_ff;

   mem_req_type mreq;
   logic [7:0]  mrd;
   logic        clr_busy;
   div_req_type dreq;
   div_rsp_type drsp;

   tcie_mem u_mem (.clock, .reset, .mem_req(mreq), .rdata(mrd), .clr_busy);
   tcie_div u_div (.clock, .reset, .div_req(dreq), .div_rsp(drsp));

   logic a_ok, b_ok;
   logic [AddrW-1:0] addr_a, addr_b;
   logic [14:0] mag_a, mag_b;
   logic signed [15:0] bv_c;
   logic signed [15:0] bv_mem;
   logic [15:0] mword;

   assign a_ok = ra_ff >= 4'd1 && ra_ff <= 4'd8;
   assign b_ok = rb_ff <= 4'd8;
   assign mag_a = av_ff[15] ? 15'(-av_ff) : av_ff[14:0];
   assign mag_b = bv_ff[15] ? 15'(-bv_ff) : bv_ff[14:0];
   assign addr_a = AddrW'(mag_a);
   assign addr_b = AddrW'(mag_b);
   assign mword = {hi_ff, mrd};
   assign bv_mem = mword[15] ? -$signed({1'b0, mword[14:0]}) : $signed({1'b0, mword[14:0]});
   assign req_ready = st_ff == ST_IDLE && !rv_ff && !clr_busy;

   // operand b once known
   always_comb begin
      if (rb_ff == 4'd0) bv_c = (imm_ff == -16'sd32768) ? -16'sd32767 : imm_ff;
      else bv_c = bv_ff;
   end

   logic signed [17:0] sum;
   logic signed [31:0] prod;
   logic        sat_c;
   logic signed [15:0] wv;

   always_comb begin
      st_in = st_ff;
      mreq = '0;
      mreq.addr = addr_b;
      dreq = '0;
      dreq.dividend = mag_a;
      dreq.divisor = bv_c[15] ? 15'(-bv_c) : bv_c[14:0];
      case (st_ff)
         ST_IDLE: if (req_valid && req_ready) st_in = ST_EXEC;
         ST_EXEC: begin
            if ((op_ff == OP_MOVE || (op_ff >= OP_ADD && op_ff <= OP_CMP && op_ff != OP_NOT))
                && a_ok && b_ok && rb_ff >= 4'd1) begin
               if (op_ff == OP_MOVE && rb_ff <= 4'd4) begin
                  mreq.we = 1'b1; mreq.addr = addr_a; mreq.wdata = wword_ff[15:8];
                  st_in = ST_WR1;
               end else if (rb_ff >= 4'd5) begin
                  st_in = ST_RD0;
               end else st_in = (op_ff == OP_DIV) ? ST_DIV : ST_DONE;
            end else st_in = (op_ff == OP_DIV && a_ok && b_ok) ? ST_DIV : ST_DONE;
         end
         ST_WR1: begin
            mreq.we = 1'b1; mreq.addr = addr_a + 1'b1; mreq.wdata = wword_ff[7:0];
            st_in = ST_DONE;
         end
         ST_RD0: begin mreq.addr = addr_b; st_in = ST_RD1; end
         ST_RD1: begin mreq.addr = addr_b + 1'b1; st_in = ST_RD2; end
         ST_RD2: st_in = (op_ff == OP_DIV) ? ST_DIV : ST_DONE;
         ST_DIV: begin
            if (bv_c == 16'sd0) st_in = ST_DONE;
            else begin dreq.start = 1'b1; st_in = ST_DONE; end
         end
         ST_DONE: begin
            if (op_ff == OP_DIV && dsign_ff && !drsp.done) st_in = ST_DONE;
            else st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Result calculation in ST_DONE.
   always_comb begin : calc
      logic signed [15:0] q;
      q = $signed({1'b0, drsp.quotient});
      if (av_ff[15] ^ bv_c[15]) q = -q;
      sum = '0; prod = '0; sat_c = 1'b0; wv = '0;
      case (op_ff)
         OP_ADD: sum = 18'(av_ff) + 18'(bv_c);
         OP_SUB: sum = 18'(av_ff) - 18'(bv_c);
         default: sum = '0;
      endcase
      prod = av_ff * bv_c;
      case (op_ff)
         OP_MOVE: wv = bv_c;
         OP_ADD, OP_SUB: begin
            wv = 16'(clamp17(sum));
            sat_c = sum > 18'sd32767 || sum < -18'sd32767;
         end
         OP_MUL: begin
            sat_c = prod > 32'sd32767 || prod < -32'sd32767;
            wv = prod > 32'sd32767 ? 16'sd32767 :
                 prod < -32'sd32767 ? -16'sd32767 : prod[15:0];
         end
         OP_DIV: wv = (bv_c == 16'sd0) ? '0 : q;
         OP_AND: wv = 16'((av_ff != 0) && (bv_c != 0));
         OP_OR:  wv = 16'((av_ff != 0) || (bv_c != 0));
         default: wv = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && req_valid && req_ready) begin
         op_ff <= req_func; ra_ff <= req_reg_a; rb_ff <= req_reg_b;
         imm_ff <= req_immediate; inv_ff <= req_in_value;
         av_ff <= (req_reg_a >= 4'd1 && req_reg_a <= 4'd8) ? regs[3'(req_reg_a - 4'd1)] : '0;
         bv_ff <= (req_reg_b >= 4'd1 && req_reg_b <= 4'd8) ? regs[3'(req_reg_b - 4'd1)] : '0;
         wword_ff <= (req_reg_b >= 4'd1 && req_reg_b <= 4'd8) ?
            (regs[3'(req_reg_b - 4'd1)][15] ?
               {1'b1, 15'(-regs[3'(req_reg_b - 4'd1)])} : regs[3'(req_reg_b - 4'd1)]) : '0;
      end
      if (st_ff == ST_RD1) hi_ff <= mrd;
      if (st_ff == ST_RD2) bv_ff <= bv_mem;
      if (st_ff == ST_DIV) dsign_ff <= bv_c != 16'sd0;
      if (st_ff == ST_EXEC) dsign_ff <= 1'b0;
   end

   // Retire: update architectural state and load the result register.
   logic retire;
   assign retire = st_ff == ST_DONE && !(op_ff == OP_DIV && dsign_ff && !drsp.done);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rv_ff <= 1'b0; ip_ff <= '0; flag_ff <= '0;
         for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
      end else begin
         st_ff <= st_in;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (retire) begin : ret
            logic [15:0] nip;
            logic [3:0]  wi;
            logic signed [15:0] wvl;
            logic [1:0]  f;
            logic signed [1:0] nf;
            logic        ov;
            logic signed [15:0] ovl;
            logic        hlt;
            nip = ip_ff + 16'd4; wi = '0; wvl = '0; f = FAULT_NONE; nf = flag_ff;
            ov = 1'b0; ovl = '0; hlt = 1'b0;
            case (op_ff)
               OP_HALT: hlt = 1'b1;
               OP_JUMP: begin
                  if (rb_ff == COND_ALWAYS || (rb_ff == COND_EQ && flag_ff == 2'sd0) ||
                      (rb_ff == COND_GT && flag_ff == 2'sd1) ||
                      (rb_ff == COND_LT && flag_ff == -2'sd1))
                     nip = ip_ff + imm_ff;
               end
               OP_IN: if (!a_ok) f = FAULT_REG;
                  else begin
                     wi = ra_ff;
                     wvl = inv_ff == -16'sd32768 ? -16'sd32767 : inv_ff;
                     if (inv_ff == -16'sd32768) f = FAULT_SAT;
                  end
               OP_OUT: if (!a_ok) f = FAULT_REG;
                  else begin ov = 1'b1; ovl = av_ff; end
               OP_NOT: if (!a_ok) f = FAULT_REG;
                  else begin wi = ra_ff; wvl = 16'(av_ff == 0); end
               OP_MOVE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_CMP: begin
                  if (!a_ok || !b_ok) f = FAULT_REG;
                  else if (!(op_ff == OP_MOVE && rb_ff >= 4'd1 && rb_ff <= 4'd4)) begin
                     if (rb_ff == 4'd0 && imm_ff == -16'sd32768) f = FAULT_SAT;
                     if (sat_c) f = FAULT_SAT;
                     if (op_ff == OP_DIV && bv_c == 16'sd0) f = FAULT_DIV;
                     if (op_ff == OP_CMP)
                        nf = av_ff > bv_c ? 2'sd1 : (av_ff < bv_c ? -2'sd1 : 2'sd0);
                     else begin wi = ra_ff; wvl = wv; end
                  end
               end
               default: ;
            endcase
            if (wi != 4'd0) regs[3'(wi - 4'd1)] <= wvl;
            ip_ff <= nip; flag_ff <= nf;
            nip_ff <= nip; widx_ff <= wi; wval_ff <= wvl; fault_ff <= f;
            ov_ff <= ov; oval_ff <= ovl; halt_ff <= hlt;
            rv_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_next_ip = nip_ff;
   assign rsp_cmp_flag = flag_ff;
   assign rsp_written_index = widx_ff;
   assign rsp_written_value = wval_ff;
   assign rsp_out_valid = ov_ff;
   assign rsp_out_value = oval_ff;
   assign rsp_halted = halt_ff;
   assign rsp_fault = fault_ff;
endmodule
`default_nettype wire

// ===== hdl/tcie_div.sv =====
// Restoring divider for 15-bit magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tcie_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tcie_pkg::div_req_type div_req,
   output tcie_pkg::div_rsp_type   div_rsp
);
   import tcie_pkg::*;
   logic [14:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [15:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[14]} - {1'b0, dsr_ff};
      if (div_req.start) begin
         rem_in = '0; quo_in = div_req.dividend; dsr_in = div_req.divisor;
         cnt_in = 4'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit and try a subtract
         if (!trial[15]) begin
            rem_in = trial[14:0];
            quo_in = {quo_ff[13:0], 1'b1};
         end else begin
            rem_in = {rem_ff[13:0], quo_ff[14]};
            quo_in = {quo_ff[13:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd14) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// ===== hdl/tcie_mem.sv =====
// Byte data memory with clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module tcie_mem (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tcie_pkg::mem_req_type mem_req,
   output logic [7:0]              rdata,
   output logic                    clr_busy
);
   import tcie_pkg::*;
   logic [7:0]       mem [MemBytes];
   logic [AddrW:0]   clr_ff, clr_in;
   logic             we;
   logic [AddrW-1:0] waddr;
   logic [7:0]       wdata;

   assign clr_busy = !clr_ff[AddrW];
   assign clr_in = clr_busy ? clr_ff + 1'b1 : clr_ff;
   assign we = clr_busy || mem_req.we;
   assign waddr = clr_busy ? clr_ff[AddrW-1:0] : mem_req.addr;
   assign wdata = clr_busy ? 8'd0 : mem_req.wdata;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[mem_req.addr];
   end
endmodule
`default_nettype wire

// ===== hdl/tcie_checker.sv =====
// Port checker for the execute core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tcie_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [3:0] rsp_written_index,
   input wire logic signed [15:0] rsp_written_value,
   input wire logic [1:0] rsp_fault,
   input wire logic signed [1:0] rsp_cmp_flag
);
   a_no_ready_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_flag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cmp_flag != 2'b10) else $error("bad compare flag");
   a_wval_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written_index != 4'd0 |-> rsp_written_value != 16'h8000)
      else $error("negative zero written");
   a_fault_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault == 2'd1 |-> rsp_written_index == 4'd0)
      else $error("faulting request wrote a register");
endmodule

bind toy_cpu_instruction_execute_core tcie_checker u_tcie_checker (.*);
`default_nettype wire

// ===== bench/tb_toy_cpu_instruction_execute_core.sv =====
// Testbench: random and directed instruction checks of the execute core against a local predictor.
`timescale 1ns / 1ps
module tb_toy_cpu_instruction_execute_core;
   import tcie_pkg::*;

   localparam int MemSize = 32768;

   typedef struct packed {
      logic [15:0] next_ip;
      logic [1:0]  cmp_flag;
      logic [3:0]  windex;
      logic [15:0] wvalue;
      logic        ovalid;
      logic [15:0] ovalue;
      logic        halted;
      logic [1:0]  fault;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_func = '0;
   logic [3:0] req_reg_a = '0;
   logic [3:0] req_reg_b = '0;
   logic signed [15:0] req_immediate = '0;
   logic signed [15:0] req_in_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_next_ip;
   logic signed [1:0] rsp_cmp_flag;
   logic [3:0] rsp_written_index;
   logic signed [15:0] rsp_written_value;
   logic rsp_out_valid;
   logic signed [15:0] rsp_out_value;
   logic rsp_halted;
   logic [1:0] rsp_fault;

   toy_cpu_instruction_execute_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   int regs[8];
   int flag;
   logic [15:0] ip;
   logic [7:0] mem[MemSize];
   outcome_type pending[$];
   int errors = 0;
   int send_idle = 0;
   int take_idle = 0;
   bit hold_rsp = 1'b0;

   function automatic int sat_val(int x, ref bit sat);
      if (x > 32767) begin sat = 1; return 32767; end
      if (x < -32767) begin sat = 1; return -32767; end
      return x;
   endfunction

   function automatic int addr_from(int v);
      return (v < 0 ? -v : v) % MemSize;
   endfunction

   function automatic int load_word(int v);
      int a;
      logic [15:0] w;
      a = addr_from(v);
      w = {mem[a], mem[(a + 1) % MemSize]};
      return w[15] ? -int'(w[14:0]) : int'(w[14:0]);
   endfunction

   function automatic void store_word(int v, int d);
      int a;
      logic [15:0] w;
      a = addr_from(v);
      w = d < 0 ? (16'h8000 | 16'(-d)) : 16'(d);
      mem[a] = w[15:8];
      mem[(a + 1) % MemSize] = w[7:0];
   endfunction

   function automatic outcome_type execute(logic [3:0] f, logic [3:0] ra, logic [3:0] rb,
                                           logic signed [15:0] imm, logic signed [15:0] inv);
      outcome_type o;
      bit sat, a_ok, b_ok, take;
      int av, bv, wv, wi, fl;
      sat = 0; wv = 0; wi = 0; fl = FAULT_NONE; bv = 0;
      o = '0;
      a_ok = ra >= 1 && ra <= 8;
      b_ok = rb <= 8;
      av = a_ok ? regs[ra - 1] : 0;
      o.next_ip = ip + 16'd4;
      case (f)
         OP_HALT: o.halted = 1;
         OP_JUMP: begin
            take = rb == COND_ALWAYS || (rb == COND_EQ && flag == 0) ||
                   (rb == COND_GT && flag == 1) || (rb == COND_LT && flag == -1);
            if (take) o.next_ip = ip + 16'(imm);
         end
         OP_IN: if (!a_ok) fl = FAULT_REG; else begin wi = ra; wv = sat_val(int'(inv), sat); end
         OP_OUT: if (!a_ok) fl = FAULT_REG; else begin o.ovalid = 1; o.ovalue = 16'(av); end
         OP_NOT: if (!a_ok) fl = FAULT_REG; else begin wi = ra; wv = av == 0; end
         OP_MOVE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_CMP: begin
            if (!a_ok || !b_ok) fl = FAULT_REG;
            else if (f == OP_MOVE && rb >= 1 && rb <= 4) store_word(av, regs[rb - 1]);
            else begin
               if (rb == 0) bv = sat_val(int'(imm), sat);
               else if (rb <= 4) bv = regs[rb - 1];
               else bv = load_word(regs[rb - 1]);
               case (f)
                  OP_MOVE: wv = bv;
                  OP_ADD: wv = sat_val(av + bv, sat);
                  OP_SUB: wv = sat_val(av - bv, sat);
                  OP_MUL: wv = sat_val(av * bv, sat);
                  OP_DIV: if (bv == 0) fl = FAULT_DIV; else wv = av / bv;
                  OP_AND: wv = av != 0 && bv != 0;
                  OP_OR: wv = av != 0 || bv != 0;
                  default: ;
               endcase
               if (f == OP_CMP) flag = av > bv ? 1 : (av < bv ? -1 : 0);
               else wi = ra;
            end
         end
         default: ;
      endcase
      if (fl == FAULT_NONE && sat) fl = FAULT_SAT;
      if (wi != 0) regs[wi - 1] = wv;
      ip = o.next_ip;
      o.cmp_flag = 2'(flag);
      o.windex = 4'(wi);
      o.wvalue = 16'(wv);
      o.fault = 2'(fl);
      return o;
   endfunction

   task automatic send(logic [3:0] f, logic [3:0] ra, logic [3:0] rb,
                       logic signed [15:0] imm, logic signed [15:0] inv);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_reg_a <= ra;
      req_reg_b <= rb;
      req_immediate <= imm;
      req_in_value <= inv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending.push_back(execute(f, ra, rb, imm, inv));
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= !reset && !hold_rsp &&
                   !(take_idle > 0 && $urandom_range(99) < take_idle);
   end

   // result checker
   always @(posedge clock) begin
      outcome_type got, exp_o;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_next_ip, rsp_cmp_flag, rsp_written_index, rsp_written_value,
                rsp_out_valid, rsp_out_value, rsp_halted, rsp_fault};
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected request result %h", $time, got);
         end else begin
            exp_o = pending.pop_front();
            if (got !== exp_o) begin
               errors++;
               $display("%0t: expected ip %h flag %h wi %h wv %h ov %h %h halt %h fault %h",
                        $time, exp_o.next_ip, exp_o.cmp_flag, exp_o.windex, exp_o.wvalue,
                        exp_o.ovalid, exp_o.ovalue, exp_o.halted, exp_o.fault);
               $display("%0t: actual   ip %h flag %h wi %h wv %h ov %h %h halt %h fault %h",
                        $time, got.next_ip, got.cmp_flag, got.windex, got.wvalue,
                        got.ovalid, got.ovalue, got.halted, got.fault);
            end
         end
      end
   end

   // drop the request line and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   // sign-magnitude friendly random values, mostly small
   function automatic logic [15:0] rnd_val();
      case ($urandom_range(3))
         0: return 16'($urandom_range(65535));
         1: return 16'($signed($urandom_range(40)) - 20);
         2: return $urandom_range(1) ? 16'sd32767 : -16'sd32767;
         default: return 16'($signed($urandom_range(600)) - 300);
      endcase
   endfunction

   task automatic test_directed();
      send(OP_IN, 4'd1, 4'd0, 16'sd0, 16'sd32767);
      send(OP_IN, 4'd2, 4'd0, 16'sd0, -16'sd32768);
      send(OP_ADD, 4'd1, 4'd2, 16'sd0, 16'sd0);
      send(OP_ADD, 4'd1, 4'd0, 16'sd5, 16'sd0);
      send(OP_SUB, 4'd2, 4'd0, 16'sd7, 16'sd0);
      send(OP_MOVE, 4'd3, 4'd0, -16'sd32768, 16'sd0);
      send(OP_MUL, 4'd3, 4'd3, 16'sd0, 16'sd0);
      send(OP_MOVE, 4'd4, 4'd0, 16'sd100, 16'sd0);
      send(OP_MOVE, 4'd4, 4'd2, 16'sd0, 16'sd0);
      send(OP_MOVE, 4'd5, 4'd8, 16'sd0, 16'sd0);
      send(OP_MOVE, 4'd6, 4'd0, 16'sd32767, 16'sd0);
      send(OP_MOVE, 4'd7, 4'd0, -16'sd32767, 16'sd0);
      send(OP_MOVE, 4'd6, 4'd4, 16'sd0, 16'sd0);
      send(OP_DIV, 4'd1, 4'd0, 16'sd0, 16'sd0);
      send(OP_DIV, 4'd6, 4'd0, -16'sd3, 16'sd0);
      send(OP_AND, 4'd6, 4'd8, 16'sd0, 16'sd0);
      send(OP_OR, 4'd8, 4'd0, 16'sd0, 16'sd0);
      send(OP_NOT, 4'd8, 4'd0, 16'sd0, 16'sd0);
      send(OP_CMP, 4'd6, 4'd7, 16'sd0, 16'sd0);
      send(OP_JUMP, 4'd0, COND_GT, -16'sd32768, 16'sd0);
      send(OP_JUMP, 4'd0, 4'd15, 16'sd8, 16'sd0);
      send(OP_OUT, 4'd6, 4'd0, 16'sd0, 16'sd0);
      send(OP_ADD, 4'd0, 4'd1, 16'sd0, 16'sd0);
      send(OP_SUB, 4'd1, 4'd9, 16'sd0, 16'sd0);
      send(OP_HALT, 4'd15, 4'd15, 16'sd0, 16'sd0);
      send(4'd15, 4'd3, 4'd3, 16'sd1, 16'sd1);
   endtask

   task automatic test_random(int count);
      logic [3:0] f, ra, rb;
      repeat (count) begin
         f = 4'($urandom_range(15));
         ra = $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
         rb = $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(8));
         if (f <= 4'd12 && $urandom_range(15) == 0) f = OP_MOVE; // favour stores/loads
         send(f, ra, rb, rnd_val(), rnd_val());
      end
   endtask

   // hold the receiver so the core fills up and stalls its input
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         test_random(6);
         begin
            int n;
            for (n = 0; n < 200; n++) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      drain();
   endtask

   initial begin
      int k;
      for (k = 0; k < 8; k++) regs[k] = 0;
      for (k = 0; k < MemSize; k++) mem[k] = 8'h00;
      flag = 0;
      ip = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle = 38; take_idle = 56;
      test_random(450);
      test_backpressure();
      send_idle = 56; take_idle = 38;
      test_random(450);
      drain();
      send_idle = 0; take_idle = 0;
      test_random(450);
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("tb_toy_cpu_instruction_execute_core OK");
      else $display("tb_toy_cpu_instruction_execute_core NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_toy_cpu_instruction_execute_core NOT OK");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/tcie_pkg.sv
hdl/tcie_div.sv
hdl/tcie_mem.sv
hdl/toy_cpu_instruction_execute_core.sv
hdl/tcie_checker.sv
bench/tb_toy_cpu_instruction_execute_core.sv
